// ===== sv/lbfop_pkg.sv =====
// ----------------------------------------------------------------------------
// lbfop_pkg
// Shared types and helpers of the lifetime best-fit offset planner.
// ----------------------------------------------------------------------------
package lbfop_pkg;

  typedef struct packed {
    logic [15:0] life_start;
    logic [15:0] life_end;
    logic [23:0] size_bytes;
    logic [3:0]  align_log2;
  } obj_t;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] blk_end;
  } free_blk_t;

  localparam int ObjW  = $bits(obj_t);
  localparam int FreeW = $bits(free_blk_t);

  function automatic logic [32:0] align_up(input logic [31:0] v, input logic [3:0] alog);
    logic [32:0] mask;
    mask = (33'd1 << alog) - 33'd1;
    return ({1'b0, v} + mask) & ~mask;
  endfunction

endpackage

// ===== sv/lbfop_ram.sv =====
// ----------------------------------------------------------------------------
// lbfop_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lbfop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lifetime_best_fit_offset_planner.sv =====
// ----------------------------------------------------------------------------
// lifetime_best_fit_offset_planner
// Lifetime-aware best-fit workspace offset planner with sequential fallback.
// ----------------------------------------------------------------------------
// Objects arrive on the input channel (in_valid/in_ready), one transaction
// per object. The transaction with last_object set starts planning and
// in_ready stays low until the run is delivered. Objects beyond
// MAX_OBJECTS are dropped.
// Planning runs on a small sequencer: a rank sort of the objects, then per
// placement a release scan over the objects and several passes over the
// free-list memory, then a linear pass for the sequential size and, when
// fallback is taken, a second one for the sequential layout.
// Results leave through an output register on out_valid/out_ready: one
// transaction per object in load order and then a totals transaction that
// carries last_result. A stalled receiver simply holds the sequencer.
// Reset clears the control state and empties the free list; the tables need
// no clearing since a run reads only what it has written.
// ----------------------------------------------------------------------------
module lifetime_best_fit_offset_planner
  import lbfop_pkg::*;
#(
  parameter int MAX_OBJECTS     = 32,
  parameter int MAX_FREE_BLOCKS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] life_start,
  input  logic [15:0] life_end,
  input  logic [23:0] size_bytes,
  input  logic [3:0]  align_log2,
  input  logic        last_object,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  object_index,
  output logic [31:0] byte_offset,
  output logic        is_totals,
  output logic [31:0] plan_bytes,
  output logic [31:0] sequential_bytes,
  output logic        used_fallback,
  output logic        last_result
);

  localparam int OBJ_AW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int OBJ_CW  = $clog2(MAX_OBJECTS + 1);
  localparam int FREE_AW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int FREE_CW = $clog2(MAX_FREE_BLOCKS + 1);

  typedef enum logic [32:0] {
    S_IDLE  = 33'd1 << 0,
    S_SR_I  = 33'd1 << 1,
    S_SR_IL = 33'd1 << 2,
    S_SR_J  = 33'd1 << 3,
    S_SR_JC = 33'd1 << 4,
    S_SR_W  = 33'd1 << 5,
    S_PL_P  = 33'd1 << 6,
    S_PL_K  = 33'd1 << 7,
    S_PL_O  = 33'd1 << 8,
    S_RL_I  = 33'd1 << 9,
    S_RL_C  = 33'd1 << 10,
    S_FT_R  = 33'd1 << 11,
    S_FT_A  = 33'd1 << 12,
    S_FT_B  = 33'd1 << 13,
    S_FT_C  = 33'd1 << 14,
    S_FT_D  = 33'd1 << 15,
    S_RM_R  = 33'd1 << 16,
    S_RM_C  = 33'd1 << 17,
    S_PL_T  = 33'd1 << 18,
    S_PL_E  = 33'd1 << 19,
    S_AD_0  = 33'd1 << 20,
    S_AD_R  = 33'd1 << 21,
    S_AD_C  = 33'd1 << 22,
    S_SQ_R  = 33'd1 << 23,
    S_SQ_C  = 33'd1 << 24,
    S_FB_0  = 33'd1 << 25,
    S_FB_R  = 33'd1 << 26,
    S_FB_C  = 33'd1 << 27,
    S_OUT_R = 33'd1 << 28,
    S_OUT_L = 33'd1 << 29,
    S_OUT_W = 33'd1 << 30,
    S_TOT   = 33'd1 << 31,
    S_FT_0  = 33'd1 << 32
  } state_t;

  state_t state, ret;

  logic [OBJ_CW-1:0]      loaded, i, j, rank, p;
  logic [MAX_OBJECTS-1:0] active;
  logic [OBJ_AW-1:0]      kreg;
  obj_t                   cur;
  logic [FREE_CW-1:0]     free_cnt, fi, wp;
  logic [31:0]            add_off, add_end, lo, hi;
  logic                   found;
  logic [FREE_AW-1:0]     best_idx;
  logic [31:0]            best_ao, best_off, best_end;
  logic [32:0]            best_waste, ao_r, waste_r;
  free_blk_t              e_r;
  logic                   fits_r;
  logic [31:0]            ws, seq, w;
  logic                   fallback;

  logic                   obj_we;
  logic [OBJ_AW-1:0]      obj_raddr;
  obj_t                   obj_wdata, obj_rdata;
  logic                   pord_we;
  logic [OBJ_AW-1:0]      pord_rdata;
  logic                   off_we;
  logic [OBJ_AW-1:0]      off_waddr;
  logic [31:0]            off_wdata, off_rdata;
  logic                   free_we;
  free_blk_t              free_wdata, free_rdata;

  logic        in_fire, goes_ahead, touch;
  logic [32:0] ws_up, seq_up, w_up;
  logic [31:0] ws_al, seq_al, w_al, tail_off;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign obj_we    = in_fire && (loaded < OBJ_CW'(MAX_OBJECTS));
  assign obj_wdata = '{life_start: life_start, life_end: life_end,
                       size_bytes: size_bytes, align_log2: align_log2};

  assign goes_ahead = (obj_rdata.life_start < cur.life_start) ||
                      ((obj_rdata.life_start == cur.life_start) &&
                       ((obj_rdata.size_bytes > cur.size_bytes) ||
                        ((obj_rdata.size_bytes == cur.size_bytes) && (j < i))));

  assign touch = (free_rdata.off <= add_end) && (add_off <= free_rdata.blk_end);

  assign ws_up    = align_up(ws, cur.align_log2);
  assign seq_up   = align_up(seq, obj_rdata.align_log2);
  assign w_up     = align_up(w, obj_rdata.align_log2);
  assign ws_al    = ws_up[31:0];
  assign seq_al   = seq_up[31:0];
  assign w_al     = w_up[31:0];
  assign tail_off = best_ao + {8'd0, cur.size_bytes};

  always_comb begin
    case (state)
      S_SR_J:  obj_raddr = j[OBJ_AW-1:0];
      S_PL_K:  obj_raddr = pord_rdata;
      default: obj_raddr = i[OBJ_AW-1:0];
    endcase
  end

  assign pord_we = (state == S_SR_W);

  always_comb begin
    off_we    = 1'b0;
    off_waddr = kreg;
    off_wdata = best_ao;
    case (state)
      S_FT_D: begin
        off_we    = !found;
        off_wdata = ws_al;
      end
      S_RM_R: begin
        off_we = (fi == free_cnt);
      end
      S_FB_C: begin
        off_we    = 1'b1;
        off_waddr = i[OBJ_AW-1:0];
        off_wdata = w_al;
      end
      default: off_we = 1'b0;
    endcase
  end

  always_comb begin
    free_we    = 1'b0;
    free_wdata = free_rdata;
    case (state)
      S_AD_R: begin
        free_we    = (fi == free_cnt);
        free_wdata = '{off: lo, blk_end: hi};
      end
      S_AD_C:  free_we = !touch;
      S_RM_C:  free_we = (fi[FREE_AW-1:0] != best_idx);
      default: free_we = 1'b0;
    endcase
  end

  lbfop_ram #(.WIDTH(ObjW), .DEPTH(MAX_OBJECTS)) u_obj_ram (
    .clk(clk), .we(obj_we), .waddr(loaded[OBJ_AW-1:0]), .wdata(obj_wdata),
    .raddr(obj_raddr), .rdata(obj_rdata)
  );

  lbfop_ram #(.WIDTH(OBJ_AW), .DEPTH(MAX_OBJECTS)) u_pord_ram (
    .clk(clk), .we(pord_we), .waddr(rank[OBJ_AW-1:0]), .wdata(i[OBJ_AW-1:0]),
    .raddr(p[OBJ_AW-1:0]), .rdata(pord_rdata)
  );

  lbfop_ram #(.WIDTH(32), .DEPTH(MAX_OBJECTS)) u_off_ram (
    .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
    .raddr(i[OBJ_AW-1:0]), .rdata(off_rdata)
  );

  lbfop_ram #(.WIDTH(FreeW), .DEPTH(MAX_FREE_BLOCKS)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(wp[FREE_AW-1:0]), .wdata(free_wdata),
    .raddr(fi[FREE_AW-1:0]), .rdata(free_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      loaded    <= '0;
      active    <= '0;
      free_cnt  <= '0;
      ws        <= '0;
      out_valid <= 1'b0;
      i         <= '0;
      j         <= '0;
      p         <= '0;
      fi        <= '0;
      wp        <= '0;
      found     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (obj_we) begin
              loaded <= loaded + OBJ_CW'(1);
            end
            if (last_object) begin
              i     <= '0;
              state <= S_SR_I;
            end
          end
        end
        S_SR_I: state <= S_SR_IL;
        S_SR_IL: begin
          cur   <= obj_rdata;
          rank  <= '0;
          j     <= '0;
          state <= S_SR_J;
        end
        S_SR_J: state <= S_SR_JC;
        S_SR_JC: begin
          if (goes_ahead) begin
            rank <= rank + OBJ_CW'(1);
          end
          j <= j + OBJ_CW'(1);
          state <= (j + OBJ_CW'(1) == loaded) ? S_SR_W : S_SR_J;
        end
        S_SR_W: begin
          i <= i + OBJ_CW'(1);
          if (i + OBJ_CW'(1) == loaded) begin
            p        <= '0;
            free_cnt <= '0;
            ws       <= '0;
            state    <= S_PL_P;
          end else begin
            state <= S_SR_I;
          end
        end
        S_PL_P: state <= S_PL_K;
        S_PL_K: begin
          kreg  <= pord_rdata;
          state <= S_PL_O;
        end
        S_PL_O: begin
          cur   <= obj_rdata;
          i     <= '0;
          state <= S_RL_I;
        end
        S_RL_I: begin
          if (i == loaded) begin
            state <= S_FT_0;
          end else if (active[i[OBJ_AW-1:0]]) begin
            state <= S_RL_C;
          end else begin
            i <= i + OBJ_CW'(1);
          end
        end
        S_RL_C: begin
          i <= i + OBJ_CW'(1);
          if (obj_rdata.life_end <= cur.life_start) begin
            active[i[OBJ_AW-1:0]] <= 1'b0;
            add_off <= off_rdata;
            add_end <= off_rdata + {8'd0, obj_rdata.size_bytes};
            ret     <= S_RL_I;
            state   <= S_AD_0;
          end else begin
            state <= S_RL_I;
          end
        end
        S_FT_0: begin
          fi    <= '0;
          found <= 1'b0;
          state <= S_FT_R;
        end
        S_FT_R: state <= (fi == free_cnt) ? S_FT_D : S_FT_A;
        S_FT_A: begin
          e_r   <= free_rdata;
          ao_r  <= align_up(free_rdata.off, cur.align_log2);
          state <= S_FT_B;
        end
        S_FT_B: begin
          fits_r  <= (({1'b0, ao_r} + 34'(cur.size_bytes)) <= 34'(e_r.blk_end));
          waste_r <= 33'(e_r.blk_end - e_r.off) - 33'(cur.size_bytes);
          state   <= S_FT_C;
        end
        S_FT_C: begin
          if (fits_r && (!found || (waste_r < best_waste) ||
                         ((waste_r == best_waste) && (ao_r[31:0] < best_ao)))) begin
            found      <= 1'b1;
            best_idx   <= fi[FREE_AW-1:0];
            best_ao    <= ao_r[31:0];
            best_off   <= e_r.off;
            best_end   <= e_r.blk_end;
            best_waste <= waste_r;
          end
          fi    <= fi + FREE_CW'(1);
          state <= S_FT_R;
        end
        S_FT_D: begin
          if (found) begin
            fi    <= '0;
            wp    <= '0;
            state <= S_RM_R;
          end else begin
            add_off <= ws;
            add_end <= ws_al;
            ws      <= ws_al + {8'd0, cur.size_bytes};
            ret     <= S_PL_E;
            state   <= S_AD_0;
          end
        end
        S_RM_R: begin
          if (fi == free_cnt) begin
            free_cnt <= wp;
            add_off  <= best_off;
            add_end  <= best_ao;
            ret      <= S_PL_T;
            state    <= S_AD_0;
          end else begin
            state <= S_RM_C;
          end
        end
        S_RM_C: begin
          if (fi[FREE_AW-1:0] != best_idx) begin
            wp <= wp + FREE_CW'(1);
          end
          fi    <= fi + FREE_CW'(1);
          state <= S_RM_R;
        end
        S_PL_T: begin
          add_off <= tail_off;
          add_end <= best_end;
          ret     <= S_PL_E;
          state   <= S_AD_0;
        end
        S_PL_E: begin
          active[kreg] <= 1'b1;
          p <= p + OBJ_CW'(1);
          if (p + OBJ_CW'(1) == loaded) begin
            i     <= '0;
            seq   <= '0;
            state <= S_SQ_R;
          end else begin
            state <= S_PL_P;
          end
        end
        S_AD_0: begin
          if ((add_off == add_end) || (free_cnt >= FREE_CW'(MAX_FREE_BLOCKS))) begin
            state <= ret;
          end else begin
            fi    <= '0;
            wp    <= '0;
            lo    <= add_off;
            hi    <= add_end;
            state <= S_AD_R;
          end
        end
        S_AD_R: begin
          if (fi == free_cnt) begin
            free_cnt <= wp + FREE_CW'(1);
            state    <= ret;
          end else begin
            state <= S_AD_C;
          end
        end
        S_AD_C: begin
          if (touch) begin
            if (free_rdata.off < lo) begin
              lo <= free_rdata.off;
            end
            if (free_rdata.blk_end > hi) begin
              hi <= free_rdata.blk_end;
            end
          end else begin
            wp <= wp + FREE_CW'(1);
          end
          fi    <= fi + FREE_CW'(1);
          state <= S_AD_R;
        end
        S_SQ_R: state <= (i == loaded) ? S_FB_0 : S_SQ_C;
        S_SQ_C: begin
          seq   <= seq_al + {8'd0, obj_rdata.size_bytes};
          i     <= i + OBJ_CW'(1);
          state <= S_SQ_R;
        end
        S_FB_0: begin
          fallback <= (ws > seq);
          i        <= '0;
          if (ws > seq) begin
            ws    <= seq;
            w     <= '0;
            state <= S_FB_R;
          end else begin
            state <= S_OUT_R;
          end
        end
        S_FB_R: begin
          if (i == loaded) begin
            i     <= '0;
            state <= S_OUT_R;
          end else begin
            state <= S_FB_C;
          end
        end
        S_FB_C: begin
          w     <= w_al + {8'd0, obj_rdata.size_bytes};
          i     <= i + OBJ_CW'(1);
          state <= S_FB_R;
        end
        S_OUT_R: begin
          if (i == loaded) begin
            object_index     <= '0;
            byte_offset      <= '0;
            is_totals        <= 1'b1;
            plan_bytes       <= ws;
            sequential_bytes <= seq;
            used_fallback    <= fallback;
            last_result      <= 1'b1;
            out_valid        <= 1'b1;
            state            <= S_TOT;
          end else begin
            state <= S_OUT_L;
          end
        end
        S_OUT_L: begin
          object_index     <= 6'(i);
          byte_offset      <= off_rdata;
          is_totals        <= 1'b0;
          plan_bytes       <= '0;
          sequential_bytes <= '0;
          used_fallback    <= 1'b0;
          last_result      <= 1'b0;
          out_valid        <= 1'b1;
          state            <= S_OUT_W;
        end
        S_OUT_W: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            i         <= i + OBJ_CW'(1);
            state     <= S_OUT_R;
          end
        end
        S_TOT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            loaded    <= '0;
            active    <= '0;
            free_cnt  <= '0;
            ws        <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/lbfop_checker.sv =====
// ----------------------------------------------------------------------------
// lbfop_checker
// Port-level checks of the offset planner, bound to the top level.
// ----------------------------------------------------------------------------
module lbfop_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] life_start,
  input logic [15:0] life_end,
  input logic [23:0] size_bytes,
  input logic [3:0]  align_log2,
  input logic        last_object,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  object_index,
  input logic [31:0] byte_offset,
  input logic        is_totals,
  input logic [31:0] plan_bytes,
  input logic [31:0] sequential_bytes,
  input logic        used_fallback,
  input logic        last_result
);

  // The block never loads while it still has results to deliver.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result transaction is pending");

  // After the totals transaction the block is ready for the next run.
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_result |=> !out_valid && in_ready)
    else $error("block not idle after the totals transaction");

  // Only the totals transaction may end a run.
  a_last_totals: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_result |-> is_totals)
    else $error("last_result on an offset transaction");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_offset) &&
      $stable(object_index) && $stable(is_totals) && $stable(plan_bytes) &&
      $stable(sequential_bytes) && $stable(used_fallback) && $stable(last_result))
    else $error("result changed while stalled");

  // A waiting input transaction holds its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(life_start) &&
      $stable(life_end) && $stable(size_bytes) && $stable(align_log2) &&
      $stable(last_object))
    else $error("input changed while waiting");

endmodule

bind lifetime_best_fit_offset_planner lbfop_checker u_lbfop_checker (.*);

// ===== sim/lifetime_best_fit_offset_planner_tb.sv =====
// ----------------------------------------------------------------------------
// lifetime_best_fit_offset_planner_tb
// Self-checking testbench of the lifetime best-fit offset planner. Runs of
// objects go in; a scoreboard predicts every offset and the totals of each
// run and compares them field by field with what the block delivers.
// ----------------------------------------------------------------------------
module lifetime_best_fit_offset_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxObj  = 32;
  localparam int MaxFree = 64;

  typedef struct {
    logic [5:0]  object_index;
    logic [31:0] byte_offset;
    logic        is_totals;
    logic [31:0] plan_bytes;
    logic [31:0] sequential_bytes;
    logic        used_fallback;
    logic        last_result;
  } plan_item_t;

  class plan_scoreboard;
    logic [15:0] obj_start[MaxObj];
    logic [15:0] obj_end[MaxObj];
    logic [23:0] obj_size[MaxObj];
    logic [3:0]  obj_alog[MaxObj];
    longint      obj_off[MaxObj];
    bit          live[MaxObj];
    int          order[MaxObj];
    longint      blk_off[MaxFree];
    longint      blk_len[MaxFree];
    int          nblk;
    longint      ws_end;
    int          loaded;
    plan_item_t  pending[$];
    int          errors;

    function longint round_up(longint v, logic [3:0] alog);
      longint a;
      a = longint'(1) << alog;
      return (v + a - 1) & ~(a - 1);
    endfunction

    function void give_back(longint off, longint len);
      int pos;
      int n;
      longint pend;
      longint bend;
      pos = 0;
      n = 0;
      if (len == 0 || nblk >= MaxFree) return;
      while (pos < nblk && blk_off[pos] <= off) pos++;
      for (int i = nblk; i > pos; i--) begin
        blk_off[i] = blk_off[i-1];
        blk_len[i] = blk_len[i-1];
      end
      blk_off[pos] = off;
      blk_len[pos] = len;
      nblk++;
      for (int i = 0; i < nblk; i++) begin
        if (n > 0) begin
          pend = blk_off[n-1] + blk_len[n-1];
          bend = blk_off[i] + blk_len[i];
          if (blk_off[i] <= pend) begin
            blk_len[n-1] = (bend > pend ? bend : pend) - blk_off[n-1];
            continue;
          end
        end
        blk_off[n] = blk_off[i];
        blk_len[n] = blk_len[i];
        n++;
      end
      nblk = n;
    endfunction

    function bit sorts_first(int a, int b);
      if (obj_start[a] != obj_start[b]) return obj_start[a] < obj_start[b];
      if (obj_size[a] != obj_size[b]) return obj_size[a] > obj_size[b];
      return a < b;
    endfunction

    function void place(int k);
      bit     found;
      int     best;
      longint best_off;
      longint best_waste;
      longint bend;
      longint ao;
      longint waste;
      longint s_off;
      longint s_len;
      longint oend;
      found = 0;
      best = 0;
      best_off = 0;
      best_waste = 0;
      for (int i = 0; i < loaded; i++)
        if (live[i] && obj_end[i] <= obj_start[k]) begin
          live[i] = 0;
          give_back(obj_off[i], obj_size[i]);
        end
      for (int i = 0; i < nblk; i++) begin
        bend = blk_off[i] + blk_len[i];
        ao = round_up(blk_off[i], obj_alog[k]);
        if (ao > bend || longint'(obj_size[k]) > bend - ao) continue;
        waste = blk_len[i] - obj_size[k];
        if (!found || waste < best_waste || (waste == best_waste && ao < best_off)) begin
          found = 1;
          best = i;
          best_off = ao;
          best_waste = waste;
        end
      end
      if (found) begin
        s_off = blk_off[best];
        s_len = blk_len[best];
        oend = best_off + obj_size[k];
        for (int i = best; i + 1 < nblk; i++) begin
          blk_off[i] = blk_off[i+1];
          blk_len[i] = blk_len[i+1];
        end
        nblk--;
        obj_off[k] = best_off;
        give_back(s_off, best_off - s_off);
        give_back(oend, s_off + s_len - oend);
      end else begin
        ao = round_up(ws_end, obj_alog[k]);
        give_back(ws_end, ao - ws_end);
        obj_off[k] = ao;
        ws_end = ao + obj_size[k];
      end
      live[k] = 1;
    endfunction

    function void note_object(logic [15:0] st, logic [15:0] en, logic [23:0] sz,
                              logic [3:0] al, logic last);
      int         j;
      longint     seq;
      longint     w;
      bit         fb;
      plan_item_t it;
      if (loaded < MaxObj) begin
        obj_start[loaded] = st;
        obj_end[loaded] = en;
        obj_size[loaded] = sz;
        obj_alog[loaded] = al;
        loaded++;
      end
      if (!last) return;
      for (int i = 0; i < loaded; i++) begin
        j = i;
        while (j > 0 && sorts_first(i, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
        live[i] = 0;
      end
      nblk = 0;
      ws_end = 0;
      for (int i = 0; i < loaded; i++) place(order[i]);
      seq = 0;
      for (int i = 0; i < loaded; i++) seq = round_up(seq, obj_alog[i]) + obj_size[i];
      fb = ws_end > seq;
      if (fb) begin
        w = 0;
        for (int i = 0; i < loaded; i++) begin
          w = round_up(w, obj_alog[i]);
          obj_off[i] = w;
          w += obj_size[i];
        end
        ws_end = seq;
      end
      for (int i = 0; i < loaded; i++) begin
        it = '{default: '0};
        it.object_index = i[5:0];
        it.byte_offset = obj_off[i][31:0];
        pending = {pending, it};
      end
      it = '{default: '0};
      it.is_totals = 1;
      it.plan_bytes = ws_end[31:0];
      it.sequential_bytes = seq[31:0];
      it.used_fallback = fb;
      it.last_result = 1;
      pending = {pending, it};
      for (int i = 0; i < MaxObj; i++) live[i] = 0;
      nblk = 0;
      ws_end = 0;
      loaded = 0;
    endfunction

    function void check_result(plan_item_t got);
      plan_item_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.object_index !== exp.object_index) begin
        $error("object_index: expected %0d, got %0d", exp.object_index, got.object_index);
        errors++;
      end
      if (got.byte_offset !== exp.byte_offset) begin
        $error("byte_offset: expected %0d, got %0d", exp.byte_offset, got.byte_offset);
        errors++;
      end
      if (got.is_totals !== exp.is_totals) begin
        $error("is_totals: expected %0d, got %0d", exp.is_totals, got.is_totals);
        errors++;
      end
      if (got.plan_bytes !== exp.plan_bytes) begin
        $error("plan_bytes: expected %0d, got %0d", exp.plan_bytes,
               got.plan_bytes);
        errors++;
      end
      if (got.sequential_bytes !== exp.sequential_bytes) begin
        $error("sequential_bytes: expected %0d, got %0d", exp.sequential_bytes,
               got.sequential_bytes);
        errors++;
      end
      if (got.used_fallback !== exp.used_fallback) begin
        $error("used_fallback: expected %0d, got %0d", exp.used_fallback, got.used_fallback);
        errors++;
      end
      if (got.last_result !== exp.last_result) begin
        $error("last_result: expected %0d, got %0d", exp.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [15:0] life_start = 0;
  logic [15:0] life_end = 0;
  logic [23:0] size_bytes = 0;
  logic [3:0]  align_log2 = 0;
  logic        last_object = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [5:0]  object_index;
  logic [31:0] byte_offset;
  logic        is_totals;
  logic [31:0] plan_bytes;
  logic [31:0] sequential_bytes;
  logic        used_fallback;
  logic        last_result;

  plan_scoreboard sb = new();
  int burst_left = 0;

  always #5 clk = ~clk;

  lifetime_best_fit_offset_planner i_dut (.*);

  always @(posedge clk) begin
    plan_item_t got;
    if (!rst && out_valid && out_ready) begin
      got.object_index = object_index;
      got.byte_offset = byte_offset;
      got.is_totals = is_totals;
      got.plan_bytes = plan_bytes;
      got.sequential_bytes = sequential_bytes;
      got.used_fallback = used_fallback;
      got.last_result = last_result;
      sb.check_result(got);
    end
  end

  // The receiver stalls in phases: free-running stretches, light and heavy stalls.
  always @(posedge clk) begin
    int phase;
    phase = ($time / 4000) % 3;
    if (rst) out_ready <= 0;
    else if (phase == 0) out_ready <= 1;
    else if (phase == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 3) == 0);
  end

  task automatic send_object(input logic [15:0] st, input logic [15:0] en,
                             input logic [23:0] sz, input logic [3:0] al, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1;
    life_start <= st;
    life_end <= en;
    size_bytes <= sz;
    align_log2 <= al;
    last_object <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_object(st, en, sz, al, last);
  endtask

  task automatic send_run(input int n, input bit wide);
    logic [15:0] st;
    logic [15:0] en;
    logic [23:0] sz;
    for (int i = 0; i < n; i++) begin
      st = wide ? 16'($urandom) : 16'($urandom_range(0, 40));
      en = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, st))
                                       : 16'(st + $urandom_range(1, 20));
      case ($urandom_range(0, 5))
        0: sz = 0;
        1: sz = 24'hFFFFFF;
        2: sz = 24'($urandom);
        default: sz = 24'($urandom_range(1, 4096));
      endcase
      send_object(st, en, sz, 4'($urandom_range(4, 12)), i == n - 1);
    end
  endtask

  initial begin
    int items;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: single object with extremes, zero size, ended-before-start,
    // same-start ties, and an overfull table.
    send_object(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 4'd12, 1);
    send_object(0, 0, 0, 4'd4, 1);
    send_object(0, 2, 100, 4'd4, 0);
    send_object(0, 2, 100, 4'd4, 0);
    send_object(2, 1, 50, 4'd12, 0);
    send_object(2, 4, 0, 4'd8, 0);
    send_object(4, 6, 30, 4'd5, 0);
    send_object(16'hAAAA, 16'h5555, 24'hAAAAAA, 4'd15, 0);
    send_object(16'h5555, 16'hAAAA, 24'h555555, 4'd0, 1);
    for (int i = 0; i < 34; i++)
      send_object(16'(i / 3), 16'(i / 3 + 2), 24'(64 * (i % 5)), 4'd4, i == 33);
    items = 0;
    while (items < 200) begin
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 10);
      send_run(n, $urandom_range(0, 3) == 0);
      items += n;
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lbfop_pkg.sv
sv/lbfop_ram.sv
sv/lifetime_best_fit_offset_planner.sv
sv/lbfop_checker.sv
sim/lifetime_best_fit_offset_planner_tb.sv
